@@ hdl/microwave_cook_timer_controller_defines.svh @@
// assertion macros for the checker file
`ifndef MICROWAVE_COOK_TIMER_CONTROLLER_DEFINES_SVH
`define MICROWAVE_COOK_TIMER_CONTROLLER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define MCTC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed in %m");

// next-cycle implication, sampled on clk, off while in reset
`define MCTC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed in %m");

`endif

@@ hdl/mctc_pkg.sv @@
`timescale 1ns / 1ps

package mctc_pkg;

  localparam logic [5:0] SECS_PER_MIN    = 6'd60;
  localparam logic [5:0] SETTING_TOP     = 6'd59;
  localparam logic [7:0] MIN_START_RESET = 8'd9;

  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_MIN_UP     = 3'd1,
    OP_MIN_DOWN   = 3'd2,
    OP_SEC_UP     = 3'd3,
    OP_SEC_DOWN   = 3'd4,
    OP_MODE       = 3'd5,
    OP_START_STOP = 3'd6,
    OP_DOOR       = 3'd7
  } opcode_t;

  typedef struct packed {
    opcode_t opcode;
    logic    door_closed;
  } item_t;

  typedef struct packed {
    logic [5:0] minutes_shown;
    logic [5:0] seconds_shown;
    logic [5:0] set_minutes;
    logic [5:0] set_seconds;
    logic       grill_on;
    logic       micro_on;
    logic       lamp_on;
    logic       buzzer_on;
    logic       active;
    logic       grill_mode;
    logic       start_error;
  } result_t;

  // settings above the top wrap to zero, otherwise count up
  function automatic logic [5:0] bump_up(input logic [5:0] v);
    logic [5:0] r;
    r = (v > SETTING_TOP) ? 6'd0 : v + 6'd1;
    return r;
  endfunction

  // saturate at zero
  function automatic logic [5:0] bump_down(input logic [5:0] v);
    logic [5:0] r;
    r = (v == 6'd0) ? 6'd0 : v - 6'd1;
    return r;
  endfunction

endpackage

@@ hdl/mctc_in_stage.sv @@
`timescale 1ns / 1ps

module mctc_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  mctc_pkg::item_t in_item,
  input  logic            take,
  output logic            vld,
  output mctc_pkg::item_t item
);
  import mctc_pkg::*;

  logic  vld_r;
  logic  vld_nxt;
  item_t item_r;
  logic  accept;

  assign in_stall = vld_r && !take;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // payload only
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

  assign vld  = vld_r;
  assign item = item_r;

endmodule

@@ hdl/mctc_core.sv @@
`timescale 1ns / 1ps

module mctc_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              vld,
  input  mctc_pkg::item_t   item,
  input  logic [7:0]        min_start,
  input  logic              out_stall,
  output logic              take,
  output logic              out_valid,
  output mctc_pkg::result_t res
);
  import mctc_pkg::*;

  result_t    res_r, res_nxt;
  logic       toggle_r, toggle_nxt;
  logic       counting_r, counting_nxt;
  logic       door_r, door_nxt;
  logic       out_vld_r;
  logic [11:0] m_ext;
  logic [11:0] s_ext;
  logic [11:0] total;
  logic        upd;

  assign take = !out_vld_r || !out_stall;
  assign upd  = take && vld;

  // minutes*60 + seconds as two shifts
  assign m_ext = {6'd0, res_r.set_minutes};
  assign s_ext = {6'd0, res_r.set_seconds};
  assign total = (m_ext << 6) - (m_ext << 2) + s_ext;

  always_comb begin
    res_nxt      = res_r;
    toggle_nxt   = toggle_r;
    counting_nxt = counting_r;
    door_nxt     = door_r;
    case (item.opcode)
      OP_TICK: begin
        if (counting_r) begin
          if (res_r.seconds_shown != 6'd0) begin
            res_nxt.seconds_shown = res_r.seconds_shown - 6'd1;
          end else if (res_r.minutes_shown != 6'd0) begin
            res_nxt.minutes_shown = res_r.minutes_shown - 6'd1;
            res_nxt.seconds_shown = SETTING_TOP;
          end
          if (res_nxt.minutes_shown == 6'd0 && res_nxt.seconds_shown == 6'd0) begin
            counting_nxt      = 1'b0;
            res_nxt.active    = 1'b0;
            res_nxt.grill_on  = 1'b0;
            res_nxt.micro_on  = 1'b0;
            res_nxt.lamp_on   = 1'b1;
            res_nxt.buzzer_on = 1'b1;
          end
        end
      end
      OP_MIN_UP:   res_nxt.set_minutes = bump_up(res_r.set_minutes);
      OP_MIN_DOWN: res_nxt.set_minutes = bump_down(res_r.set_minutes);
      OP_SEC_UP:   res_nxt.set_seconds = bump_up(res_r.set_seconds);
      OP_SEC_DOWN: res_nxt.set_seconds = bump_down(res_r.set_seconds);
      OP_MODE: begin
        if (!res_r.active) begin
          res_nxt.grill_mode = !res_r.grill_mode;
        end
      end
      OP_START_STOP: begin
        toggle_nxt = !toggle_r;
        if (!toggle_r) begin
          res_nxt.active = 1'b1;
          // a seconds setting of 60 carries into the minutes
          if (res_r.set_seconds == SECS_PER_MIN) begin
            res_nxt.minutes_shown = res_r.set_minutes + 6'd1;
            res_nxt.seconds_shown = 6'd0;
          end else begin
            res_nxt.minutes_shown = res_r.set_minutes;
            res_nxt.seconds_shown = res_r.set_seconds;
          end
          if (total <= {4'd0, min_start}) begin
            res_nxt.start_error = 1'b1;
          end else begin
            res_nxt.start_error = 1'b0;
            if (door_r) begin
              counting_nxt     = 1'b1;
              res_nxt.grill_on = res_r.grill_mode;
              res_nxt.micro_on = !res_r.grill_mode;
            end
          end
        end else begin
          res_nxt.set_minutes   = 6'd0;
          res_nxt.set_seconds   = 6'd0;
          res_nxt.minutes_shown = 6'd0;
          res_nxt.seconds_shown = 6'd0;
          counting_nxt          = 1'b0;
          res_nxt.active        = 1'b0;
          res_nxt.grill_on      = 1'b0;
          res_nxt.micro_on      = 1'b0;
          res_nxt.start_error   = 1'b0;
        end
      end
      OP_DOOR: begin
        door_nxt = item.door_closed;
        if (item.door_closed) begin
          res_nxt.lamp_on = 1'b1;
        end else if (res_r.active) begin
          counting_nxt      = 1'b0;
          res_nxt.grill_on  = 1'b0;
          res_nxt.micro_on  = 1'b0;
          res_nxt.buzzer_on = 1'b1;
        end else begin
          res_nxt.buzzer_on = 1'b0;
        end
      end
      default: res_nxt = res_r;
    endcase
  end

  // state doubles as the result register: it only moves when a result is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r      <= '0;
      toggle_r   <= 1'b0;
      counting_r <= 1'b0;
      door_r     <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (take) begin
        out_vld_r <= vld;
      end
      if (upd) begin
        res_r      <= res_nxt;
        toggle_r   <= toggle_nxt;
        counting_r <= counting_nxt;
        door_r     <= door_nxt;
      end
    end
  end

  assign out_valid = out_vld_r;
  assign res       = res_r;

endmodule

@@ hdl/microwave_cook_timer_controller.sv @@
`timescale 1ns / 1ps

// microwave oven cook timer controller
// input channel: in_valid / in_stall with in_opcode and in_door_closed; one
//   event per item (tick, minute/second up/down, mode, start/stop, door level)
// result channel: out_valid / out_stall; each item yields exactly one result
//   showing the display, the settings and all drives after that event
// config: cfg_wr_en / cfg_wr_data write the minimum start time (reset 9);
//   write only while no item is in flight
// path: an accepted item goes through the input register, then the result register, to out_*
// throughput: one item per cycle while no result is stalled; the input and result
//   registers form a two-stage pipeline, the state update is a single pass of logic
// stall: while out_stall holds a result, the result and all timer state hold;
//   at most one more item is taken into the input register, then in_stall rises
// reset (rst_n low, synchronous): settings, timer, drives and mode clear,
//   both stages empty, threshold back to 9
module microwave_cook_timer_controller (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_opcode,
  input  logic       in_door_closed,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [5:0] out_minutes_shown,
  output logic [5:0] out_seconds_shown,
  output logic [5:0] out_set_minutes,
  output logic [5:0] out_set_seconds,
  output logic       out_grill_on,
  output logic       out_micro_on,
  output logic       out_lamp_on,
  output logic       out_buzzer_on,
  output logic       out_active,
  output logic       out_grill_mode,
  output logic       out_start_error
);
  import mctc_pkg::*;

  logic [7:0] min_start_r;
  item_t      in_item;
  item_t      item;
  logic       vld;
  logic       take;
  result_t    res;

  // start threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_start_r <= MIN_START_RESET;
    end else if (cfg_wr_en) begin
      min_start_r <= cfg_wr_data;
    end
  end

  assign in_item.opcode      = opcode_t'(in_opcode);
  assign in_item.door_closed = in_door_closed;

  // stage one: input register
  mctc_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .take     (take),
    .vld      (vld),
    .item     (item)
  );

  // stage two: event decode, timer state and result register
  mctc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .vld       (vld),
    .item      (item),
    .min_start (min_start_r),
    .out_stall (out_stall),
    .take      (take),
    .out_valid (out_valid),
    .res       (res)
  );

  assign out_minutes_shown = res.minutes_shown;
  assign out_seconds_shown = res.seconds_shown;
  assign out_set_minutes   = res.set_minutes;
  assign out_set_seconds   = res.set_seconds;
  assign out_grill_on      = res.grill_on;
  assign out_micro_on      = res.micro_on;
  assign out_lamp_on       = res.lamp_on;
  assign out_buzzer_on     = res.buzzer_on;
  assign out_active        = res.active;
  assign out_grill_mode    = res.grill_mode;
  assign out_start_error   = res.start_error;

endmodule

@@ hdl/mctc_checker.sv @@
`timescale 1ns / 1ps

`include "microwave_cook_timer_controller_defines.svh"

module mctc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [5:0] out_seconds_shown,
  input logic       out_grill_on,
  input logic       out_micro_on,
  input logic       out_active,
  input logic       out_grill_mode
);

  // a stalled result stays offered
  `MCTC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

  // never both heaters at once
  `MCTC_ASSERT_NOW(a_one_heater, out_valid, !(out_grill_on && out_micro_on))

  // a heater only runs inside a cook cycle
  `MCTC_ASSERT_NOW(a_heat_active, out_valid && (out_grill_on || out_micro_on), out_active)

  // the grill heater follows the selected mode
  `MCTC_ASSERT_NOW(a_grill_mode, out_valid && out_grill_on, out_grill_mode)

  // shown seconds stay below a minute
  `MCTC_ASSERT_NOW(a_sec_range, out_valid, out_seconds_shown < 6'd60)

endmodule

bind microwave_cook_timer_controller mctc_checker u_mctc_checker (.*);
